// ----- hdl/utar_pkg.sv -----
`timescale 1ns / 1ps
// Package for the unsigned-to-ASCII radix converter.
// Holds widths, state and command codes, and the digit-to-ASCII function.
package utar_pkg;

   localparam int VALUE_BITS = 32;
   localparam int REQ_VALUE_W = 32;
   localparam int IN_BITS = (VALUE_BITS < REQ_VALUE_W) ? VALUE_BITS : REQ_VALUE_W;
   localparam int NUM_DIGITS = (IN_BITS + 2) / 3;
   localparam int DIG_W = NUM_DIGITS * 4;
   localparam int OCT_W = NUM_DIGITS * 3;
   localparam int BIT_CNT_W = $clog2(IN_BITS);
   localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

   localparam logic [4:0] RADIX_OCT = 5'd8;
   localparam logic [4:0] RADIX_DEC = 5'd10;
   localparam logic [4:0] RADIX_HEX = 5'd16;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_NONE = 8'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT,
      ST_ERROR
   } utar_state_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_LOAD_DEC,
      CMD_LOAD_OCT,
      CMD_LOAD_HEX,
      CMD_DABBLE,
      CMD_SHIFT
   } utar_cmd_type;

   function automatic logic [7:0] utar_ascii(input logic [3:0] digit);
      logic [7:0] ch;
      if (digit < 4'd10) begin
         ch = CHAR_ZERO + {4'd0, digit};
      end else begin
         ch = CHAR_A + {4'd0, digit} - 8'd10;
      end
      return ch;
   endfunction

endpackage

// ----- hdl/utar_digit_reg.sv -----
`timescale 1ns / 1ps
// Digit shift register: loads octal/hex digits directly, builds decimal
// digits by shift-and-add-3, and shifts digits out top first. Uses utar_pkg.
module utar_digit_reg
   import utar_pkg::*;
(
   input  logic               clock,
   input  utar_cmd_type       cmd,
   input  logic [IN_BITS-1:0] value_in,
   output logic [3:0]         top_digit
);

   logic [IN_BITS-1:0] bin_ff, bin_in;
   logic [DIG_W-1:0]   dig_ff, dig_in;
   logic [DIG_W-1:0]   fixed;
   logic [OCT_W-1:0]   oct_ext;
   logic [DIG_W-1:0]   oct_spread;

   always_comb begin
      oct_ext = OCT_W'(value_in);
      for (int i = 0; i < NUM_DIGITS; i++) begin
         oct_spread[4*i +: 4] = {1'b0, oct_ext[3*i +: 3]};
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            fixed[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            fixed[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      dig_in = dig_ff;
      unique case (cmd)
         CMD_HOLD: begin
         end
         CMD_LOAD_DEC: begin
            bin_in = value_in;
            dig_in = '0;
         end
         CMD_LOAD_OCT: dig_in = oct_spread;
         CMD_LOAD_HEX: dig_in = DIG_W'(value_in);
         CMD_DABBLE: begin
            dig_in = {fixed[DIG_W-2:0], bin_ff[IN_BITS-1]};
            bin_in = {bin_ff[IN_BITS-2:0], 1'b0};
         end
         CMD_SHIFT: dig_in = {dig_ff[DIG_W-5:0], 4'd0};
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      dig_ff <= dig_in;
   end

   assign top_digit = dig_ff[DIG_W-1 -: 4];

endmodule

// ----- hdl/unsigned_to_ascii_radix.sv -----
`timescale 1ns / 1ps
// Top level of the unsigned-to-ASCII converter (radix 8, 10, 16).
// Uses utar_pkg and utar_digit_reg.
//
//   channel | ports                                  | direction
//   req     | req_valid req_ready req_value req_radix | in
//   rsp     | rsp_valid rsp_ready rsp_character       | out
//           | rsp_last rsp_bad_radix                  |
//
// Decimal: the accept state loads the digit register, shift-and-add-3 steps
// build the digits, leading zeros are dropped one at a time (one digit is always
// kept), then one character goes out per digit. Octal and hex load directly.
// One word at a time; a stalled rsp holds the digit sequencer in place.
// Reset is synchronous and clears only the sequencer and rsp_valid.
module unsigned_to_ascii_radix
   import utar_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [REQ_VALUE_W-1:0] req_value,
   input  logic [4:0]             req_radix,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last,
   output logic                   rsp_bad_radix
);

   utar_state_type       state_ff, state_in;
   utar_cmd_type         cmd;
   logic [BIT_CNT_W-1:0] bit_ff, bit_in;
   logic [DIG_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_character_ff, rsp_character_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_bad_radix_ff, rsp_bad_radix_in;
   logic [3:0]           top_digit;
   logic                 accept, out_free, is_oct, is_dec, is_hex;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_oct   = (req_radix == RADIX_OCT);
   assign is_dec   = (req_radix == RADIX_DEC);
   assign is_hex   = (req_radix == RADIX_HEX);

   utar_digit_reg u_digits (
      .clock     (clock),
      .cmd       (cmd),
      .value_in  (req_value[IN_BITS-1:0]),
      .top_digit (top_digit)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (is_dec)          state_in = ST_CONVERT;
               else if (is_oct || is_hex)    state_in = ST_SKIP;
               else                          state_in = ST_ERROR;
            end
         end
         ST_CONVERT: if (bit_ff == '0) state_in = ST_SKIP;
         ST_SKIP: begin
            if (!(top_digit == 4'd0 && cnt_ff > DIG_CNT_W'(1))) state_in = ST_EMIT;
         end
         ST_EMIT: if (out_free && cnt_ff == DIG_CNT_W'(1)) state_in = ST_IDLE;
         ST_ERROR: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd              = CMD_HOLD;
      req_ready        = (state_ff == ST_IDLE);
      bit_in           = bit_ff;
      cnt_in           = cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_bad_radix_in = rsp_bad_radix_ff;
      unique case (state_ff)
         ST_IDLE: begin
            bit_in = BIT_CNT_W'(IN_BITS - 1);
            cnt_in = DIG_CNT_W'(NUM_DIGITS);
            if (accept) begin
               priority if (is_dec) cmd = CMD_LOAD_DEC;
               else if (is_oct)     cmd = CMD_LOAD_OCT;
               else if (is_hex)     cmd = CMD_LOAD_HEX;
               else                 cmd = CMD_HOLD;
            end
         end
         ST_CONVERT: begin
            cmd    = CMD_DABBLE;
            bit_in = bit_ff - 1'b1;
         end
         ST_SKIP: begin
            if (top_digit == 4'd0 && cnt_ff > DIG_CNT_W'(1)) begin
               cmd    = CMD_SHIFT;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd              = CMD_SHIFT;
               cnt_in           = cnt_ff - 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_character_in = utar_ascii(top_digit);
               rsp_last_in      = (cnt_ff == DIG_CNT_W'(1));
               rsp_bad_radix_in = 1'b0;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CHAR_NONE;
               rsp_last_in      = 1'b1;
               rsp_bad_radix_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_ff       <= bit_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
      rsp_bad_radix_ff <= rsp_bad_radix_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_radix = rsp_bad_radix_ff;

   a_bad_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_radix_ff |-> rsp_last_ff && rsp_character_ff == CHAR_NONE)
      else $error("bad radix word malformed");

   a_digit_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bad_radix_ff |->
         (rsp_character_ff >= CHAR_ZERO && rsp_character_ff <= CHAR_ZERO + 8'd9) ||
         (rsp_character_ff >= CHAR_A && rsp_character_ff <= CHAR_A + 8'd5))
      else $error("digit word is not a lower-case digit");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT || state_ff == ST_SKIP |-> cnt_ff != '0)
      else $error("digit count ran out while emitting");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("sequencer idle right after accept");

endmodule
